// ===== rtl/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: parse phase codes, result kind codes
// and the result record passed from the parser to the top level.
// No dependencies.
`default_nettype none

package wsd_pkg;

   // Parse phases.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_SKIP    = 3'd5;
   localparam logic [2:0] PH_HDR1_CL = 3'd6;

   // Length forms.
   localparam logic [1:0] LEN_FORM_7  = 2'd0;
   localparam logic [1:0] LEN_FORM_16 = 2'd1;
   localparam logic [1:0] LEN_FORM_64 = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_CLOSE     = 3'd1;
   localparam logic [2:0] KIND_NOT_FINAL = 3'd2;
   localparam logic [2:0] KIND_UNMASKED  = 3'd3;
   localparam logic [2:0] KIND_EMPTY     = 3'd4;

   // Header bit masks and extended length markers.
   localparam logic [7:0] FIN_BIT      = 8'h80;
   localparam logic [7:0] MASK_BIT     = 8'h80;
   localparam logic [7:0] CLOSE_BIT    = 8'h08;
   localparam logic [7:0] LEN7_MASK    = 8'h7F;
   localparam logic [6:0] LEN7_EXT16   = 7'd126;
   localparam logic [6:0] LEN7_EXT64   = 7'd127;

   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] payload_byte;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/wsd_parser.sv =====
// Frame parser for the WebSocket frame deframer: holds the parse state and
// produces at most one result for each accepted byte. Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               frame_start,
   output wsd_pkg::result_type     result
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [1:0]  len_form_ff, len_form_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_pos_ff, key_pos_in;

   logic [3:0]  hdr_idx_inc;
   logic [3:0]  ext_need;
   logic [6:0]  len7;
   logic [7:0]  key_byte;

   assign hdr_idx_inc = hdr_idx_ff + 4'd1;
   assign ext_need    = (len_form_ff == wsd_pkg::LEN_FORM_16) ? wsd_pkg::EXT16_BYTES
                                                              : wsd_pkg::EXT64_BYTES;
   assign len7        = 7'(rx_byte & wsd_pkg::LEN7_MASK);

   always_comb begin
      case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      len_form_in = len_form_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      key_pos_in  = key_pos_ff;
      result      = '0;

      if (frame_start) begin
         // A start mark abandons whatever frame was in progress.
         hdr_idx_in  = 4'd0;
         len_form_in = wsd_pkg::LEN_FORM_7;
         remain_in   = 64'd0;
         key_pos_in  = 2'd0;
         if ((rx_byte & wsd_pkg::FIN_BIT) == 8'd0) begin
            phase_in     = wsd_pkg::PH_SKIP;
            result.valid = 1'b1;
            result.kind  = wsd_pkg::KIND_NOT_FINAL;
         end else if ((rx_byte & wsd_pkg::CLOSE_BIT) != 8'd0) begin
            phase_in = wsd_pkg::PH_HDR1_CL;
         end else begin
            phase_in = wsd_pkg::PH_HDR1;
         end
      end else begin
         case (phase_ff)
            wsd_pkg::PH_HDR1, wsd_pkg::PH_HDR1_CL: begin
               if ((rx_byte & wsd_pkg::MASK_BIT) == 8'd0) begin
                  phase_in     = wsd_pkg::PH_SKIP;
                  result.valid = 1'b1;
                  result.kind  = wsd_pkg::KIND_UNMASKED;
               end else if (phase_ff == wsd_pkg::PH_HDR1_CL) begin
                  phase_in     = wsd_pkg::PH_SKIP;
                  result.valid = 1'b1;
                  result.kind  = wsd_pkg::KIND_CLOSE;
               end else begin
                  remain_in  = 64'd0;
                  hdr_idx_in = 4'd0;
                  if (len7 == wsd_pkg::LEN7_EXT16) begin
                     len_form_in = wsd_pkg::LEN_FORM_16;
                     phase_in    = wsd_pkg::PH_EXTLEN;
                  end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                     len_form_in = wsd_pkg::LEN_FORM_64;
                     phase_in    = wsd_pkg::PH_EXTLEN;
                  end else begin
                     len_form_in = wsd_pkg::LEN_FORM_7;
                     remain_in   = {57'd0, len7};
                     key_in      = 32'd0;
                     phase_in    = wsd_pkg::PH_MASK;
                  end
               end
            end
            wsd_pkg::PH_EXTLEN: begin
               remain_in  = {remain_ff[55:0], rx_byte};
               hdr_idx_in = hdr_idx_inc;
               if (hdr_idx_inc >= ext_need) begin
                  hdr_idx_in = 4'd0;
                  key_in     = 32'd0;
                  phase_in   = wsd_pkg::PH_MASK;
               end
            end
            wsd_pkg::PH_MASK: begin
               key_in     = {key_ff[23:0], rx_byte};
               hdr_idx_in = hdr_idx_inc;
               if (hdr_idx_inc >= wsd_pkg::KEY_BYTES) begin
                  hdr_idx_in = 4'd0;
                  key_pos_in = 2'd0;
                  if (remain_ff == 64'd0) begin
                     phase_in     = wsd_pkg::PH_SKIP;
                     result.valid = 1'b1;
                     result.kind  = wsd_pkg::KIND_EMPTY;
                  end else begin
                     phase_in = wsd_pkg::PH_DATA;
                  end
               end
            end
            wsd_pkg::PH_DATA: begin
               result.valid        = 1'b1;
               result.kind         = wsd_pkg::KIND_PAYLOAD;
               result.payload_byte = rx_byte ^ key_byte;
               result.last         = (remain_ff == 64'd1);
               remain_in           = remain_ff - 64'd1;
               key_pos_in          = key_pos_ff + 2'd1;
               if (remain_ff == 64'd1) begin
                  phase_in = wsd_pkg::PH_SKIP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsd_pkg::PH_IDLE;
         hdr_idx_ff  <= 4'd0;
         len_form_ff <= wsd_pkg::LEN_FORM_7;
         remain_ff   <= 64'd0;
         key_ff      <= 32'd0;
         key_pos_ff  <= 2'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         len_form_ff <= len_form_in;
         remain_ff   <= remain_in;
         key_ff      <= key_in;
         key_pos_ff  <= key_pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: input handshake, parser and the
// registered result stage. Depends on wsd_pkg and wsd_parser.
//
// Usage: frame bytes enter one per transaction on the req_ channel, with
// req_frame_start high on the first header byte of each frame. Each byte
// causes zero or one result on the rsp_ channel: an unmasked payload byte
// (rsp_last on the final one), a close request, a dropped frame (not final
// or not masked) or an empty message. Bytes after the payload, and bytes
// with no frame open, produce nothing.
// A result appears in the output register in the cycle after the byte that
// caused it is accepted. Throughput: one byte per cycle unless the receiver
// stalls, set by the single parse step between the input port and output register.
// The block takes a new byte whenever the output register is empty or is
// being read in the same cycle; if the receiver stalls while a result waits,
// req_ready drops until that result is taken.
// Reset (synchronous, active high) returns the parser to waiting for a start
// mark and empties the output register.
`default_nettype none

module websocket_frame_deframer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_last
);

   wsd_pkg::result_type result;

   logic       req_accept;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = result.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         kind_ff <= result.kind;
         byte_ff <= result.payload_byte;
         last_ff <= result.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last         = last_ff;

   // A byte that produces a result must show it on the next cycle.
   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      req_accept && result.valid |=> rsp_valid)
      else $error("accepted result did not reach the output register");

   // The input side never stalls while the output register is empty.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with an empty output register");

   // Only payload bytes may carry the last flag.
   a_last_only_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == wsd_pkg::KIND_PAYLOAD)
      else $error("last flag set on a non-payload result");

   // Status results carry a zero data byte.
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != wsd_pkg::KIND_PAYLOAD |-> rsp_payload_byte == 8'd0)
      else $error("status result with nonzero data byte");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for websocket_frame_deframer_top: a directed table of frame bytes and then
// random frames go in over req_, and every rsp_ transaction is checked against typed expectations or a predictor.
// Depends on wsd_pkg and websocket_frame_deframer_top.
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] pbyte;
      logic       last;
   } deframed_type;

   // One offered byte, with the expectation typed in when typed is set.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       typed;
      logic       x_has;
      logic [2:0] x_kind;
      logic [7:0] x_byte;
      logic       x_last;
   } stim_item_type;

   localparam logic [13:0] X_PRED      = {1'b0, 1'b0, wsd_pkg::KIND_PAYLOAD, 8'h00, 1'b0};
   localparam logic [13:0] X_NONE      = {1'b1, 1'b0, wsd_pkg::KIND_PAYLOAD, 8'h00, 1'b0};
   localparam logic [13:0] X_NOT_FINAL = {1'b1, 1'b1, wsd_pkg::KIND_NOT_FINAL, 8'h00, 1'b0};
   localparam logic [13:0] X_UNMASKED  = {1'b1, 1'b1, wsd_pkg::KIND_UNMASKED, 8'h00, 1'b0};
   localparam logic [13:0] X_CLOSE     = {1'b1, 1'b1, wsd_pkg::KIND_CLOSE, 8'h00, 1'b0};
   localparam logic [13:0] X_EMPTY     = {1'b1, 1'b1, wsd_pkg::KIND_EMPTY, 8'h00, 1'b0};
   localparam int DIR_ROWS = 24;
   localparam int RANDOM_ITEMS = 1150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last;

   stim_item_type byte_queue [$];
   deframed_type  pending_results [$];
   stim_item_type offered;
   int            planned = 0;
   int            fail_count = 0;
   int            results_seen = 0;
   int            burst_left = 8;
   int            gap_left = 0;
   int            rx_cycle = 0;
   int            hold_left = 0;
   int            holds_done = 0;

   // Predictor state.
   logic [2:0]  dp_phase = wsd_pkg::PH_IDLE;
   logic [3:0]  dp_index = 4'd0;
   logic [1:0]  dp_form = wsd_pkg::LEN_FORM_7;
   logic [63:0] dp_remaining = 64'd0;
   logic [31:0] dp_key = 32'd0;
   logic [1:0]  dp_keypos = 2'd0;

   websocket_frame_deframer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

   task automatic deframe_byte(input logic [7:0] b, input logic s,
                               output bit has, output deframed_type r);
      logic [3:0] need;
      logic [7:0] key;
      has = 1'b0;
      r = {wsd_pkg::KIND_PAYLOAD, 8'h00, 1'b0};
      if (s) begin
         dp_index = 4'd0;
         dp_form = wsd_pkg::LEN_FORM_7;
         dp_remaining = 64'd0;
         dp_keypos = 2'd0;
         if ((b & wsd_pkg::FIN_BIT) == 8'h00) begin
            dp_phase = wsd_pkg::PH_SKIP;
            has = 1'b1;
            r.kind = wsd_pkg::KIND_NOT_FINAL;
         end else begin
            dp_phase = ((b & wsd_pkg::CLOSE_BIT) != 8'h00) ? wsd_pkg::PH_HDR1_CL
                                                           : wsd_pkg::PH_HDR1;
         end
      end else begin
         case (dp_phase)
            wsd_pkg::PH_HDR1, wsd_pkg::PH_HDR1_CL: begin
               if ((b & wsd_pkg::MASK_BIT) == 8'h00) begin
                  dp_phase = wsd_pkg::PH_SKIP;
                  has = 1'b1;
                  r.kind = wsd_pkg::KIND_UNMASKED;
               end else if (dp_phase == wsd_pkg::PH_HDR1_CL) begin
                  dp_phase = wsd_pkg::PH_SKIP;
                  has = 1'b1;
                  r.kind = wsd_pkg::KIND_CLOSE;
               end else begin
                  dp_remaining = 64'd0;
                  dp_index = 4'd0;
                  if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
                     dp_form = wsd_pkg::LEN_FORM_16;
                     dp_phase = wsd_pkg::PH_EXTLEN;
                  end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
                     dp_form = wsd_pkg::LEN_FORM_64;
                     dp_phase = wsd_pkg::PH_EXTLEN;
                  end else begin
                     dp_form = wsd_pkg::LEN_FORM_7;
                     dp_remaining = {57'd0, b[6:0]};
                     dp_key = 32'd0;
                     dp_phase = wsd_pkg::PH_MASK;
                  end
               end
            end
            wsd_pkg::PH_EXTLEN: begin
               need = (dp_form == wsd_pkg::LEN_FORM_16) ? wsd_pkg::EXT16_BYTES
                                                        : wsd_pkg::EXT64_BYTES;
               dp_remaining = {dp_remaining[55:0], b};
               dp_index = dp_index + 4'd1;
               if (dp_index >= need) begin
                  dp_index = 4'd0;
                  dp_key = 32'd0;
                  dp_phase = wsd_pkg::PH_MASK;
               end
            end
            wsd_pkg::PH_MASK: begin
               dp_key = {dp_key[23:0], b};
               dp_index = dp_index + 4'd1;
               if (dp_index >= wsd_pkg::KEY_BYTES) begin
                  dp_index = 4'd0;
                  dp_keypos = 2'd0;
                  if (dp_remaining == 64'd0) begin
                     dp_phase = wsd_pkg::PH_SKIP;
                     has = 1'b1;
                     r.kind = wsd_pkg::KIND_EMPTY;
                  end else begin
                     dp_phase = wsd_pkg::PH_DATA;
                  end
               end
            end
            wsd_pkg::PH_DATA: begin
               // The first key byte sits in the top bits and pairs with position zero.
               key = dp_key[8 * (3 - dp_keypos) +: 8];
               has = 1'b1;
               r.kind = wsd_pkg::KIND_PAYLOAD;
               r.pbyte = b ^ key;
               r.last = (dp_remaining == 64'd1);
               dp_remaining = dp_remaining - 64'd1;
               dp_keypos = dp_keypos + 2'd1;
               if (dp_remaining == 64'd0) dp_phase = wsd_pkg::PH_SKIP;
            end
            default: ;
         endcase
      end
   endtask

   function automatic stim_item_type dir_row(int i);
      case (i)
         0:  return {8'h00, 1'b1, X_NOT_FINAL};
         1:  return {8'hFF, 1'b0, X_NONE};
         2:  return {8'h81, 1'b1, X_NONE};
         3:  return {8'h05, 1'b0, X_UNMASKED};
         4:  return {8'h88, 1'b1, X_NONE};
         5:  return {8'h80, 1'b0, X_CLOSE};
         6:  return {8'h82, 1'b1, X_NONE};
         7:  return {8'h80, 1'b0, X_NONE};
         8:  return {8'hFF, 1'b0, X_NONE};
         9:  return {8'h00, 1'b0, X_NONE};
         10: return {8'hAA, 1'b0, X_NONE};
         11: return {8'h55, 1'b0, X_EMPTY};
         12: return {8'h81, 1'b1, X_NONE};
         13: return {8'h83, 1'b0, X_NONE};
         14: return {8'h12, 1'b0, X_NONE};
         15: return {8'h34, 1'b0, X_NONE};
         16: return {8'h56, 1'b0, X_NONE};
         17: return {8'h78, 1'b0, X_NONE};
         18: return {8'h00, 1'b0, X_PRED};
         19: return {8'hFF, 1'b0, X_PRED};
         20: return {8'h12, 1'b0, X_PRED};
         21: return {8'h7F, 1'b0, X_NONE};
         22: return {8'hFF, 1'b1, X_NONE};
         default: return {8'hFF, 1'b0, X_CLOSE};
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic s, input bit counted);
      byte_queue.push_back({b, s, X_PRED});
      if (counted) planned++;
   endtask

   // Mostly well-formed frames with random content; the rest are dropped, close,
   // truncated frames and stray bytes.
   task automatic add_frame();
      logic [7:0]  body [$];
      logic [63:0] len;
      logic [7:0]  rb;
      logic [2:0]  rsv;
      int          pick;
      int          n;
      int          keep;
      bit          huge;
      bit          is_close;
      pick = $urandom_range(0, 99);
      rsv = 3'($urandom_range(0, 7));
      huge = 1'b0;
      is_close = (pick >= 75 && pick < 80);
      len = 64'd0;
      if (pick >= 95) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(rand_byte(), 1'b0, 1'b0);
         return;
      end
      rb = rand_byte();
      if (pick >= 80 && pick < 85) begin
         body.push_back({1'b0, rb[6:0]});
      end else begin
         body.push_back({1'b1, rsv, is_close, rb[2:0]});
         rb = rand_byte();
         if (pick >= 85 && pick < 90) begin
            body.push_back({1'b0, rb[6:0]});
         end else if (is_close) begin
            body.push_back({1'b1, rb[6:0]});
         end else begin
            if (pick >= 60 && pick < 70) begin
               len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 300))
                                                 : 64'($urandom_range(0, 40));
               body.push_back({1'b1, wsd_pkg::LEN7_EXT16});
               body.push_back(len[15:8]);
               body.push_back(len[7:0]);
            end else if (pick >= 70 && pick < 75) begin
               huge = ($urandom_range(0, 2) == 0);
               len = huge ? {$urandom, $urandom} : 64'($urandom_range(0, 20));
               body.push_back({1'b1, wsd_pkg::LEN7_EXT64});
               for (int i = 7; i >= 0; i--) body.push_back(len[8 * i +: 8]);
            end else begin
               len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                                 : 64'($urandom_range(0, 12));
               body.push_back({1'b1, len[6:0]});
            end
            repeat (4) body.push_back(rand_byte());
            // A huge 64-bit length is cut short by the next start mark.
            n = huge ? int'($urandom_range(0, 30)) : int'(len);
            repeat (n) body.push_back(rand_byte());
         end
      end
      keep = body.size();
      if (pick >= 90 && pick < 95 && body.size() > 1)
         keep = int'($urandom_range(1, body.size() - 1));
      for (int i = 0; i < keep; i++) push_byte(body[i], i == 0, 1'b1);
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) push_byte(rand_byte(), 1'b0, 1'b0);
      end
   endtask

   task automatic record_accept(input stim_item_type it);
      bit           has;
      deframed_type r;
      deframe_byte(it.rx_byte, it.frame_start, has, r);
      if (it.typed) begin
         if (it.x_has) pending_results.push_back({it.x_kind, it.x_byte, it.x_last});
      end else if (has) begin
         pending_results.push_back(r);
      end
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      bit give;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) record_accept(offered);
         if (!req_valid || req_ready) begin
            give = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (byte_queue.size() > 0) begin
               offered = byte_queue.pop_front();
               give = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= give;
            if (give) begin
               req_rx_byte <= offered.rx_byte;
               req_frame_start <= offered.frame_start;
            end
         end
      end
   end

   // Receiver: result check, then a stall pattern drawn from five modes in turn,
   // with two long hold-offs that back the block up into its input.
   always @(posedge clock) begin
      deframed_type got;
      deframed_type want;
      logic         ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_payload_byte, rsp_last};
            results_seen++;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: kind %0d byte %02h last %0d",
                           got.kind, got.pbyte, got.last);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected kind %0d byte %02h last %0d,",
                               " got kind %0d byte %02h last %0d"},
                              want.kind, want.pbyte, want.last,
                              got.kind, got.pbyte, got.last);
               end
            end
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (holds_done < 2 && results_seen >= 250 + 450 * holds_done) begin
            holds_done++;
            hold_left = 300;
            ready_next = 1'b0;
         end else begin
            case ((rx_cycle / 64) % 5)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = (rx_cycle % 4 == 0);
               3: ready_next = ($urandom_range(0, 7) == 0);
               default: ready_next = (rx_cycle % 3 != 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) byte_queue.push_back(dir_row(i));
      wait_drained();
      while (planned < RANDOM_ITEMS / 2) add_frame();
      // Hold the sender back until everything in flight has come out.
      wait_drained();
      while (planned < RANDOM_ITEMS) add_frame();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
